@@ hw/rtl/arp_responder_with_cache_core_assert.svh @@
// Assertion macros shared by the ARP responder RTL.
`ifndef ARP_RESPONDER_WITH_CACHE_CORE_ASSERT_SVH
`define ARP_RESPONDER_WITH_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define ARPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define ARPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/arpr_pkg.sv @@
// Package: ARP responder payload types, codes and job format.
`default_nettype none

package arpr_pkg;

  localparam int ARPR_CACHE_ENTRIES = 8;
  localparam int ARPR_QUEUE_DEPTH   = 2;

  localparam int ARPR_MAC_W     = 48;
  localparam int ARPR_IP_W      = 32;
  localparam int ARPR_CFG_W     = 48;
  localparam int ARPR_CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [ARPR_CFG_IDX_W-1:0] REG_LOCAL_MAC = 2'd0;
  localparam logic [ARPR_CFG_IDX_W-1:0] REG_LOCAL_IP  = 2'd1;

  // ARP opcodes (host order)
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  // Result status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_REPLY    = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_CACHED   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic                  cmd;
    logic [15:0]           opcode;
    logic [ARPR_MAC_W-1:0] sender_mac;
    logic [ARPR_IP_W-1:0]  sender_ip;
    logic [ARPR_IP_W-1:0]  target_ip;
    logic [ARPR_IP_W-1:0]  query_ip;
  } arpr_in_t;

  typedef struct packed {
    logic [2:0]            status;
    logic                  reply_valid;
    logic [ARPR_MAC_W-1:0] reply_dst_mac;
    logic [ARPR_IP_W-1:0]  reply_dst_ip;
    logic                  wake_pending;
    logic                  hit;
    logic [ARPR_MAC_W-1:0] hit_mac;
  } arpr_out_t;

  // What the back end has to do with a queued item
  typedef enum logic [1:0] {
    JOB_NONE   = 2'd0,
    JOB_REPLY  = 2'd1,
    JOB_INSERT = 2'd2,
    JOB_LOOKUP = 2'd3
  } arpr_kind_t;

  typedef struct packed {
    arpr_kind_t            kind;
    logic [ARPR_MAC_W-1:0] mac;
    logic [ARPR_IP_W-1:0]  ip;
  } arpr_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } arpr_q_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/arp_responder_with_cache_core.sv @@
// Top level of the ARP responder with its small ARP cache.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_stall  | in_data  (arpr_in_t)
//  out     | output    | out_valid / out_stall| out_data (arpr_out_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// An item passes through the cache engine as dequeue, parallel match and result,
//   and the engine takes no new item until the last one's result is registered.
// out_valid rises after the job passes the queue, cur, the match vectors and out_data.
// The front queue holds 2 decoded jobs; in_stall rises only when it is full.
// The result register frees the engine as soon as out_stall drops.
// rst (sync) empties the table at once through per-slot occupied flags.
`default_nettype none

`include "arp_responder_with_cache_core_assert.svh"

module arp_responder_with_cache_core
  import arpr_pkg::*;
#(
  parameter int CacheEntries = ARPR_CACHE_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire arpr_in_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output arpr_out_t                      out_data,
  input  wire logic                      cfg_we,
  input  wire logic [ARPR_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ARPR_CFG_W-1:0]     cfg_data
);

  // Station addresses. local_mac is the source of reply frames, built
  // downstream; only local_ip takes part in the decode here.
  logic [ARPR_MAC_W-1:0] local_mac;
  logic [ARPR_IP_W-1:0]  local_ip;

  // front -> queue -> back
  logic           q_push;
  logic           q_pop;
  arpr_job_t      q_in_job;
  arpr_job_t      q_out_job;
  arpr_q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_mac <= '0;
      local_ip  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_MAC: local_mac <= cfg_data[ARPR_MAC_W-1:0];
        REG_LOCAL_IP:  local_ip  <= cfg_data[ARPR_IP_W-1:0];
        default:       ;  // unknown index: write dropped
      endcase
    end
  end

  // Decode each transfer into a job; requests for us become reply orders here.
  arpr_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .local_ip (local_ip),
    .q_status (q_status),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  // Decouples input transfers from table work.
  arpr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in_job),
    .pop       (q_pop),
    .pop_data  (q_out_job),
    .q_status  (q_status)
  );

  // Table lookups, inserts and reply results, in queue order, one job at a time.
  arpr_back #(
    .CacheEntries (CacheEntries)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A MAC write lands in the register in the next cycle.
  `ARPR_ASSERT_NEXT(a_cfg_mac, cfg_we && cfg_index == REG_LOCAL_MAC, local_mac == $past(cfg_data[ARPR_MAC_W-1:0]), "local_mac write lost")
  // Wake goes out exactly with an insertion.
  `ARPR_ASSERT_NOW(a_wake_ins, out_valid, out_data.wake_pending == (out_data.status == ST_INSERTED), "wake_pending disagrees with status")
  // Reply order flag and status agree.
  `ARPR_ASSERT_NOW(a_reply_st, out_valid, out_data.reply_valid == (out_data.status == ST_REPLY), "reply_valid disagrees with status")

endmodule

`default_nettype wire

@@ hw/rtl/arpr_fifo.sv @@
// Short job queue between the classifier and the cache engine.
`default_nettype none

module arpr_fifo
  import arpr_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire arpr_job_t      push_data,
  input  wire logic           pop,
  output arpr_job_t           pop_data,
  output arpr_q_status_t      q_status
);

  localparam int PtrW = $clog2(ARPR_QUEUE_DEPTH);
  localparam int CntW = $clog2(ARPR_QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(ARPR_QUEUE_DEPTH - 1);

  arpr_job_t       mem [ARPR_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign q_status.full  = (count == CntW'(ARPR_QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/arpr_front.sv @@
// Input side: takes items, decodes opcode and command, answers requests.
`default_nettype none

module arpr_front
  import arpr_pkg::*;
(
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire arpr_in_t             in_data,
  input  wire logic [ARPR_IP_W-1:0] local_ip,
  input  wire arpr_q_status_t       q_status,
  output logic                      q_push,
  output arpr_job_t                 q_job
);

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_job.kind = JOB_NONE;
    q_job.mac  = in_data.sender_mac;
    q_job.ip   = in_data.sender_ip;
    if (in_data.cmd) begin
      q_job.kind = JOB_LOOKUP;
      q_job.ip   = in_data.query_ip;
    end else if (in_data.opcode == OP_REQUEST) begin
      if (in_data.target_ip == local_ip) begin
        q_job.kind = JOB_REPLY;
      end
    end else if (in_data.opcode == OP_REPLY && in_data.sender_ip != '0) begin
      // a zero sender IP is never cached; empty slots are marked by occupied flags
      q_job.kind = JOB_INSERT;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/arpr_back.sv @@
// Cache engine: register table, parallel match, insert and result register.
`default_nettype none

module arpr_back
  import arpr_pkg::*;
#(
  parameter int CacheEntries = ARPR_CACHE_ENTRIES
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire arpr_q_status_t q_status,
  input  wire arpr_job_t      q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output arpr_out_t           out_data
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_CMP  = 3'b010,
    BK_RES  = 3'b100
  } bk_state_t;

  bk_state_t state;
  bk_state_t state_next;

  arpr_job_t cur;

  logic [CacheEntries-1:0] occupied;
  logic [ARPR_IP_W-1:0]    ent_ip  [CacheEntries];
  logic [ARPR_MAC_W-1:0]   ent_mac [CacheEntries];

  logic [CacheEntries-1:0] match_vec;
  logic [CacheEntries-1:0] empty_vec;
  logic [CacheEntries-1:0] first_empty;
  logic [ARPR_MAC_W-1:0]   match_mac;

  logic      fire;
  logic      ins_we;
  arpr_out_t res;

  assign q_pop = (state == BK_IDLE) && !q_status.empty;
  assign fire  = (state == BK_RES) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_status.empty) state_next = BK_CMP;
      BK_CMP:  state_next = BK_RES;
      BK_RES:  if (fire) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  // compare every slot against the job address, register the vectors
  always_ff @(posedge clk) begin
    if (state == BK_CMP) begin
      for (int i = 0; i < CacheEntries; i++) begin
        match_vec[i] <= occupied[i] && (ent_ip[i] == cur.ip);
        empty_vec[i] <= !occupied[i];
      end
    end
  end

  assign first_empty = empty_vec & (~empty_vec + CacheEntries'(1));

  // at most one slot matches, so an OR of the gated MACs selects it
  always_comb begin
    match_mac = '0;
    for (int i = 0; i < CacheEntries; i++) begin
      if (match_vec[i]) begin
        match_mac = match_mac | ent_mac[i];
      end
    end
  end

  always_comb begin
    res    = '0;
    ins_we = 1'b0;
    res.status = ST_NONE;
    case (cur.kind)
      JOB_REPLY: begin
        res.status        = ST_REPLY;
        res.reply_valid   = 1'b1;
        res.reply_dst_mac = cur.mac;
        res.reply_dst_ip  = cur.ip;
      end
      JOB_INSERT: begin
        if (|match_vec) begin
          res.status = ST_CACHED;
        end else if (empty_vec == '0) begin
          res.status = ST_FULL;
        end else begin
          res.status       = ST_INSERTED;
          res.wake_pending = 1'b1;
          ins_we           = 1'b1;
        end
      end
      JOB_LOOKUP: begin
        res.hit     = |match_vec;
        res.hit_mac = match_mac;
      end
      default: begin
        res.status = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (fire && ins_we) begin
      occupied <= occupied | first_empty;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CacheEntries; i++) begin
      if (fire && ins_we && first_empty[i]) begin
        ent_ip[i]  <= cur.ip;
        ent_mac[i] <= cur.mac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire
